>>> rtl/arp_pkg.sv
// Shared types and constants of the ARP resolver/responder.
// Holds beat layouts, the front-to-back command and the protocol codes.
// No dependencies.
package arp_pkg;

  localparam int unsigned MAC_W       = 48;
  localparam int unsigned IP_W        = 32;
  localparam int unsigned IN_TDATA_W  = 272;
  localparam int unsigned OUT_TDATA_W = 296;
  localparam int unsigned APB_ADDR_W  = 4;
  localparam int unsigned APB_DATA_W  = 64;
  localparam int unsigned REG_SEL_BIT = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [MAC_W-1:0] BCAST_MAC   = {MAC_W{1'b1}};
  localparam logic [15:0]      ETYPE_IPV4  = 16'h0800;
  localparam logic [15:0]      ETYPE_ARP   = 16'h0806;
  localparam logic [15:0]      HW_ETHERNET = 16'h0001;
  localparam logic [7:0]       MAC_LEN     = 8'd6;
  localparam logic [7:0]       IP_LEN      = 8'd4;
  localparam logic [15:0]      OPC_REQUEST = 16'h0001;
  localparam logic [15:0]      OPC_REPLY   = 16'h0002;

  // Register select: paddr bit REG_SEL_BIT picks the register.
  localparam logic REG_OWN_MAC = 1'b0;
  localparam logic REG_OWN_IP  = 1'b1;

  localparam logic OP_SEND = 1'b0;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_SEND_IP   = 3'd1,
    ACT_ARP_REQ   = 3'd2,
    ACT_ARP_REPLY = 3'd3,
    ACT_DELIVER   = 3'd4
  } arp_action_e;

  typedef enum logic [1:0] {
    CMD_SEND,
    CMD_ARP,
    CMD_DELIVER,
    CMD_DROP
  } arp_kind_e;

  // Input beat, last field in the lowest bits.
  typedef struct packed {
    logic [31:0] rx_target_ip;
    logic [31:0] rx_sender_ip;
    logic [47:0] rx_sender_mac;
    logic [15:0] rx_arp_opcode;
    logic [7:0]  rx_proto_len;
    logic [7:0]  rx_hw_len;
    logic [15:0] rx_proto_type;
    logic [15:0] rx_hw_type;
    logic [15:0] rx_ether_type;
    logic [47:0] rx_dest_mac;
    logic [31:0] dest_ip;
  } arp_in_t;

  // Result beat payload, last field in the lowest bits.
  typedef struct packed {
    logic        retry_needed;
    logic [31:0] tx_arp_target_ip;
    logic [47:0] tx_arp_target_mac;
    logic [31:0] tx_arp_sender_ip;
    logic [47:0] tx_arp_sender_mac;
    logic [15:0] tx_arp_opcode;
    logic [15:0] tx_ether_type;
    logic [47:0] tx_src_mac;
    logic [47:0] tx_dest_mac;
  } arp_res_t;

  // Classified work item from front to back.
  typedef struct packed {
    arp_kind_e   kind;
    logic [7:0]  slot;
    logic [31:0] ip;
    logic [47:0] mac;
    logic        own_target;
    logic        is_request;
  } arp_cmd_t;

endpackage

>>> rtl/arp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module arp_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/arp_front.sv
// Front part: takes input beats, checks headers and turns each into a command.
// Depends on arp_pkg.
module arp_front #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [arp_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  logic                           s_axis_tuser,
  input  logic [arp_pkg::MAC_W-1:0]      own_mac_i,
  input  logic [arp_pkg::IP_W-1:0]       own_ip_i,
  input  logic                           queue_full_i,
  output logic                           cmd_push_o,
  output arp_pkg::arp_cmd_t              cmd_o
);
  import arp_pkg::*;

  // Reciprocal of the table size scaled by 2^16, rounded up; the quotient
  // estimate below is exact for every 8-bit address byte.
  localparam int unsigned SLOT_RECIP = (65536 + TABLE_ENTRIES - 1) / TABLE_ENTRIES;

  arp_in_t in;
  logic    hdr_ok;

  // Remainder of an address byte by the table size.
  function automatic logic [7:0] slot_of(input logic [7:0] v);
    logic [23:0] prod;
    logic [15:0] quo_n;
    prod  = 24'(v) * 24'(SLOT_RECIP);
    quo_n = 16'(prod[23:16]) * 16'(TABLE_ENTRIES);
    return v - quo_n[7:0];
  endfunction

  assign in            = arp_in_t'(s_axis_tdata);
  assign s_axis_tready = !queue_full_i;
  assign cmd_push_o    = s_axis_tvalid && !queue_full_i;

  assign hdr_ok = (in.rx_hw_type == HW_ETHERNET) && (in.rx_hw_len == MAC_LEN) &&
                  (in.rx_proto_type == ETYPE_IPV4) && (in.rx_proto_len == IP_LEN);

  always_comb begin
    cmd_o            = '0;
    cmd_o.mac        = in.rx_sender_mac;
    cmd_o.own_target = (in.rx_target_ip == own_ip_i);
    cmd_o.is_request = (in.rx_arp_opcode == OPC_REQUEST);
    if (s_axis_tuser == OP_SEND) begin
      cmd_o.kind = CMD_SEND;
      cmd_o.ip   = in.dest_ip;
      cmd_o.slot = slot_of(in.dest_ip[7:0]);
    end else begin
      cmd_o.ip   = in.rx_sender_ip;
      cmd_o.slot = slot_of(in.rx_sender_ip[7:0]);
      if (in.rx_ether_type == ETYPE_ARP) begin
        cmd_o.kind = hdr_ok ? CMD_ARP : CMD_DROP;
      end else if (in.rx_ether_type == ETYPE_IPV4 && in.rx_dest_mac == own_mac_i) begin
        cmd_o.kind = CMD_DELIVER;
      end else begin
        cmd_o.kind = CMD_DROP;
      end
    end
  end

endmodule

>>> rtl/arp_fifo.sv
// Short command queue between the front and back parts.
// Depends on arp_pkg.
module arp_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  arp_pkg::arp_cmd_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output arp_pkg::arp_cmd_t data_o
);
  import arp_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  arp_cmd_t         slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/arp_back.sv
// Back part: looks up and updates the MAC table, builds and holds the result beat.
// Depends on arp_pkg and arp_ram.
module arp_back #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  input  arp_pkg::arp_cmd_t         cmd_i,
  output logic                      cmd_pop_o,
  input  logic [arp_pkg::MAC_W-1:0] own_mac_i,
  input  logic [arp_pkg::IP_W-1:0]  own_ip_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output arp_pkg::arp_action_e      action_o,
  output arp_pkg::arp_res_t         res_o
);
  import arp_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_OUT
  } state_e;

  state_e                   state_q;
  arp_cmd_t                 cmd_q;
  arp_action_e              action_q, action_d;
  arp_res_t                 res_q, res_d;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [IDX_W-1:0]         idx;
  logic [MAC_W-1:0]         rdata;
  logic [MAC_W-1:0]         entry;
  logic                     hit;
  logic                     tbl_we;

  assign idx       = cmd_q.slot[IDX_W-1:0];
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;

  arp_ram #(
    .WIDTH (MAC_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (idx),
    .wdata_i (cmd_q.mac),
    .re_i    (cmd_pop_o),
    .raddr_i (cmd_i.slot[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  // Entries never written read as empty.
  assign entry = valid_q[idx] ? rdata : BCAST_MAC;
  assign hit   = (entry != BCAST_MAC);

  always_comb begin
    res_d    = '0;
    action_d = ACT_NONE;
    tbl_we   = 1'b0;
    case (cmd_q.kind)
      CMD_SEND: begin
        res_d.tx_src_mac = own_mac_i;
        if (hit) begin
          action_d            = ACT_SEND_IP;
          res_d.tx_dest_mac   = entry;
          res_d.tx_ether_type = ETYPE_IPV4;
        end else begin
          action_d                = ACT_ARP_REQ;
          res_d.tx_dest_mac       = BCAST_MAC;
          res_d.tx_ether_type     = ETYPE_ARP;
          res_d.tx_arp_opcode     = OPC_REQUEST;
          res_d.tx_arp_sender_mac = own_mac_i;
          res_d.tx_arp_sender_ip  = own_ip_i;
          res_d.tx_arp_target_mac = BCAST_MAC;
          res_d.tx_arp_target_ip  = cmd_q.ip;
          res_d.retry_needed      = 1'b1;
        end
      end
      CMD_ARP: begin
        // Refresh a known sender; learn it when the ARP frame targets our IP.
        tbl_we = (state_q == ST_LOOK) && (hit || cmd_q.own_target);
        if (cmd_q.own_target && cmd_q.is_request) begin
          action_d                = ACT_ARP_REPLY;
          res_d.tx_dest_mac       = cmd_q.mac;
          res_d.tx_src_mac        = own_mac_i;
          res_d.tx_ether_type     = ETYPE_ARP;
          res_d.tx_arp_opcode     = OPC_REPLY;
          res_d.tx_arp_sender_mac = own_mac_i;
          res_d.tx_arp_sender_ip  = own_ip_i;
          res_d.tx_arp_target_mac = cmd_q.mac;
          res_d.tx_arp_target_ip  = cmd_q.ip;
        end
      end
      CMD_DELIVER: begin
        action_d = ACT_DELIVER;
      end
      default: begin
        action_d = ACT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (state_q == ST_LOOK) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      action_q <= ACT_NONE;
      valid_q  <= '0;
    end else begin
      if (tbl_we) begin
        valid_q[idx] <= 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          action_q <= action_d;
          state_q  <= ST_OUT;
        end
        ST_OUT: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o = (state_q == ST_OUT);
  assign action_o    = action_q;
  assign res_o       = res_q;

endmodule

>>> rtl/arp_resolver_responder_top.sv
// Top level of the ARP resolver/responder: config registers, front, queue, back.
// Depends on arp_pkg, arp_front, arp_fifo, arp_back and arp_ram.
//
// Usage
//   s_axis carries one beat per item: tuser is op (0 send to an IP, 1 received
//   frame), tdata the address and header fields. m_axis returns exactly one
//   result beat per item, in order: tuser is the action code, tdata the frame
//   header to transmit and the retry flag.
//   own_mac (byte address 0) and own_ip (byte address 8) are set over APB
//   while no item is in flight; both reset to zero.
// Timing
//   The front classifies a beat in the cycle it is accepted and queues it.
//   The back pops it, reads the MAC table RAM (registered read), then looks
//   up or updates the entry and loads the result register. The back works
//   on one item at a time and pops the next only after m_axis takes the
//   result.
// Reset and stalls
//   Reset clears all table valid bits, so every entry reads empty at once;
//   no clearing pass is needed. While m_axis stalls the result holds and the
//   queue still takes up to two more beats before s_axis_tready drops.
module arp_resolver_responder_top #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // s_axis_tdata, low bit up: dest_ip, rx_dest_mac, rx_ether_type, rx_hw_type,
  // rx_proto_type, rx_hw_len, rx_proto_len, rx_arp_opcode, rx_sender_mac,
  // rx_sender_ip, rx_target_ip
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [arp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                            s_axis_tuser,  // op
  // m_axis_tdata, low bit up: tx_dest_mac, tx_src_mac, tx_ether_type,
  // tx_arp_opcode, tx_arp_sender_mac, tx_arp_sender_ip, tx_arp_target_mac,
  // tx_arp_target_ip, retry_needed, zero fill
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [arp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [2:0]                      m_axis_tuser,  // action
  // APB configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [arp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [arp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [arp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import arp_pkg::*;

  logic [MAC_W-1:0] own_mac_q;
  logic [IP_W-1:0]  own_ip_q;
  logic             cfg_we;

  arp_cmd_t         push_cmd, head_cmd;
  logic             cmd_push, queue_full, head_valid, cmd_pop;
  arp_action_e      action;
  arp_res_t         res;

  // Configuration registers: write on the APB access phase.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q <= '0;
      own_ip_q  <= '0;
    end else if (cfg_we) begin
      if (paddr[REG_SEL_BIT] == REG_OWN_MAC) begin
        own_mac_q <= pwdata[MAC_W-1:0];
      end else begin
        own_ip_q <= pwdata[IP_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[REG_SEL_BIT] == REG_OWN_MAC) begin
      prdata = APB_DATA_W'(own_mac_q);
    end else begin
      prdata = APB_DATA_W'(own_ip_q);
    end
  end

  // Classify incoming beats.
  arp_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .own_mac_i     (own_mac_q),
    .own_ip_i      (own_ip_q),
    .queue_full_i  (queue_full),
    .cmd_push_o    (cmd_push),
    .cmd_o         (push_cmd)
  );

  // Decouple front and back.
  arp_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (push_cmd),
    .full_o  (queue_full),
    .pop_i   (cmd_pop),
    .valid_o (head_valid),
    .data_o  (head_cmd)
  );

  // Table lookup/update and result register.
  arp_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (cmd_pop),
    .own_mac_i   (own_mac_q),
    .own_ip_i    (own_ip_q),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .action_o    (action),
    .res_o       (res)
  );

  assign m_axis_tuser = action;
  assign m_axis_tdata = {{(OUT_TDATA_W - $bits(arp_res_t)){1'b0}}, res};

  // A silent result carries no header at all.
  a_none_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (action == ACT_NONE || action == ACT_DELIVER) |-> res == '0)
    else $error("nonzero header on a result without a frame");

  // Retry goes out exactly with a broadcast request.
  a_retry_on_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.retry_needed == (action == ACT_ARP_REQ)))
    else $error("retry flag does not match ARP request action");

  // Every transmitted frame carries our own source address.
  a_src_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (action == ACT_SEND_IP || action == ACT_ARP_REQ ||
                      action == ACT_ARP_REPLY) |-> res.tx_src_mac == own_mac_q)
    else $error("transmitted source MAC differs from own MAC");

  // The back only pops while the queue holds a command.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> head_valid)
    else $error("command popped from an empty queue");

endmodule
